>>> hw/rtl/ufsef_pkg.sv
// Shared constants and the forest entry type of the spanning-edge filter.
`timescale 1ns / 1ps

package ufsef_pkg;

	// Vertex capacity of the forest and the width of a vertex index.
	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = $clog2(MAX_VERTICES);

	// Fixed field widths.
	localparam int END_W  = 11;
	localparam int CNT_W  = 10;
	localparam int RANK_W = 4;

	// Epoch tag kept with each entry; a tag other than the current epoch
	// marks the entry as a singleton.
	localparam int EPOCH_W = 8;

	localparam logic [END_W-1:0]  VC_RESET = END_W'(1024);
	localparam logic [RANK_W-1:0] RANK_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [IDX_W-1:0]   parent;
		logic [RANK_W-1:0]  rank;
	} entry_t;

endpackage

>>> hw/rtl/ufsef_ifs.sv
// Handshake channels of the spanning-edge filter: edges, results, configuration.
`timescale 1ns / 1ps

interface ufsef_edge_if;
	logic                        valid;
	logic                        ready;
	logic [ufsef_pkg::END_W-1:0] end_a;
	logic [ufsef_pkg::END_W-1:0] end_b;
	logic                        new_graph;
	logic                        last_edge;

	modport source (output valid, end_a, end_b, new_graph, last_edge, input ready);
	modport sink   (input valid, end_a, end_b, new_graph, last_edge, output ready);
endinterface

interface ufsef_result_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic                        bad_vertex;
	logic [ufsef_pkg::CNT_W-1:0] tree_edges;
	logic                        spanning_found;

	modport source (output valid, accepted, bad_vertex, tree_edges, spanning_found,
		input ready);
	modport sink   (input valid, accepted, bad_vertex, tree_edges, spanning_found,
		output ready);
endinterface

interface ufsef_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [ufsef_pkg::END_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/ufsef_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module ufsef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/union_find_spanning_edge_filter_core.sv
// Top level of the spanning-edge filter: union-find forest with rank and path compression.
`timescale 1ns / 1ps

// Kruskal edge filter. Feed edges sorted by weight on the edges channel, one
// word per edge with 1-based endpoints; each edge yields one result word with
// the accept flag, the bad-endpoint flag, the running tree-edge count and, on
// an edge marked last_edge, whether vertex_count-1 tree edges were formed.
// new_graph resets the forest and the count before its own edge is handled.
// The forest lives in one 1024-entry RAM (parent, rank and an epoch tag per
// entry) with one access port each way. An edge takes these RAM steps in
// order: accept, then per endpoint a read of the endpoint, a climb along a
// path of d links to the root and, when d > 0, a fresh read of the endpoint
// and a rewrite of that path to point at the root, then the union (with a
// rank bump when the two ranks tie) and the posting of the result. With
// union by rank d stays at most 10 for 1024 vertices. A bad edge skips the
// lookups and the union. After reset, and on every 255th new_graph edge
// (epoch tag wrap), a clearing pass writes all 1024 entries, one per cycle,
// before edges are taken again; configuration writes are taken at any time
// and must only happen while no edge is in flight. The result sits in an
// output register, so the next edge is taken while an earlier result still
// waits for the sink.
module union_find_spanning_edge_filter_core (
	input  logic            clk,
	input  logic            arst_n,
	ufsef_edge_if.sink      edges,
	ufsef_result_if.source  results,
	ufsef_cfg_if.sink       cfg
);

	localparam int IDX_W   = ufsef_pkg::IDX_W;
	localparam int END_W   = ufsef_pkg::END_W;
	localparam int CNT_W   = ufsef_pkg::CNT_W;
	localparam int RANK_W  = ufsef_pkg::RANK_W;
	localparam int EPOCH_W = ufsef_pkg::EPOCH_W;

	// Sequencer states.
	localparam logic [3:0] S_SWEEP  = 4'd0;  // clearing pass over the RAM
	localparam logic [3:0] S_IDLE   = 4'd1;  // wait for an edge word
	localparam logic [3:0] S_START  = 4'd2;  // issue read of the endpoint
	localparam logic [3:0] S_UP     = 4'd3;  // climb to the root
	localparam logic [3:0] S_CSTART = 4'd4;  // reissue read of the endpoint
	localparam logic [3:0] S_COMP   = 4'd5;  // rewrite path to the root
	localparam logic [3:0] S_UNITE  = 4'd6;  // link roots by rank
	localparam logic [3:0] S_RANK   = 4'd7;  // bump rank of the new root
	localparam logic [3:0] S_DONE   = 4'd8;  // post the result word

	logic [3:0]         state_q;
	logic [IDX_W-1:0]   sweep_q;
	logic               sweep_item_q;  // an edge waits behind the clearing pass
	logic [EPOCH_W-1:0] epoch_q;
	logic [END_W-1:0]   vcount_q;
	logic [CNT_W-1:0]   count_q;

	// Per-edge working registers.
	logic [IDX_W-1:0]   a_idx_q;
	logic [IDX_W-1:0]   b_idx_q;
	logic               bad_q;
	logic               last_q;
	logic               acc_q;
	logic               side_q;        // 0: endpoint a, 1: endpoint b
	logic [IDX_W-1:0]   node_q;        // entry whose read is in flight
	logic [IDX_W-1:0]   root_a_q;
	logic [IDX_W-1:0]   root_b_q;
	logic [RANK_W-1:0]  rank_a_q;
	logic [RANK_W-1:0]  rank_b_q;

	// Output register.
	logic               out_valid_q;
	logic               out_acc_q;
	logic               out_bad_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_span_q;

	// RAM port.
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	ufsef_pkg::entry_t  ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	ufsef_pkg::entry_t  ram_rdata;

	logic [END_W-1:0]   vc_eff;
	logic               in_fire;
	logic               out_fire;
	logic               edge_bad;
	logic               rd_live;
	logic [IDX_W-1:0]   rd_parent;
	logic [RANK_W-1:0]  rd_rank;
	logic [IDX_W-1:0]   start_idx;
	logic [IDX_W-1:0]   root_sel;
	logic               span;

	ufsef_ram #(
		.WIDTH ($bits(ufsef_pkg::entry_t)),
		.DEPTH (ufsef_pkg::MAX_VERTICES)
	) u_forest (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Clamp the vertex count to the forest capacity.
	assign vc_eff = (32'(vcount_q) > ufsef_pkg::MAX_VERTICES)
		? END_W'(ufsef_pkg::MAX_VERTICES) : vcount_q;

	assign edge_bad = (edges.end_a == '0) || (edges.end_b == '0)
		|| (edges.end_a > vc_eff) || (edges.end_b > vc_eff);

	assign edges.ready = (state_q == S_IDLE);
	assign in_fire     = edges.valid && edges.ready;
	assign cfg.ready   = 1'b1;

	assign results.valid          = out_valid_q;
	assign results.accepted       = out_acc_q;
	assign results.bad_vertex     = out_bad_q;
	assign results.tree_edges     = out_count_q;
	assign results.spanning_found = out_span_q;
	assign out_fire               = out_valid_q && results.ready;

	// An entry tagged with an older epoch reads as a rank-0 singleton.
	assign rd_live   = (ram_rdata.tag == epoch_q);
	assign rd_parent = rd_live ? ram_rdata.parent : node_q;
	assign rd_rank   = rd_live ? ram_rdata.rank : '0;

	assign start_idx = side_q ? b_idx_q : a_idx_q;
	assign root_sel  = side_q ? root_b_q : root_a_q;

	assign span = last_q && (vc_eff != '0) && (END_W'(count_q) == vc_eff - 1'b1);

	// RAM access per state. A write and a read never hit the same entry in
	// one cycle: the compression write targets a non-root node while the read
	// goes to its parent, and every other read is issued in a cycle of its own.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = node_q;
		case (state_q)
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
			end
			S_START: begin
				ram_re    = !bad_q;
				ram_raddr = start_idx;
			end
			S_UP: begin
				ram_re    = (rd_parent != node_q);
				ram_raddr = rd_parent;
			end
			S_CSTART: begin
				ram_re    = 1'b1;
				ram_raddr = start_idx;
			end
			S_COMP: begin
				ram_we           = 1'b1;
				ram_waddr        = node_q;
				ram_wdata.tag    = epoch_q;
				ram_wdata.parent = root_sel;
				ram_wdata.rank   = rd_rank;
				ram_re           = (rd_parent != root_sel);
				ram_raddr        = rd_parent;
			end
			S_UNITE: begin
				ram_we        = (root_a_q != root_b_q);
				ram_wdata.tag = epoch_q;
				if (rank_a_q > rank_b_q) begin
					ram_waddr        = root_b_q;
					ram_wdata.parent = root_a_q;
					ram_wdata.rank   = rank_b_q;
				end else begin
					ram_waddr        = root_a_q;
					ram_wdata.parent = root_b_q;
					ram_wdata.rank   = rank_a_q;
				end
			end
			S_RANK: begin
				ram_we           = 1'b1;
				ram_waddr        = root_b_q;
				ram_wdata.tag    = epoch_q;
				ram_wdata.parent = root_b_q;
				ram_wdata.rank   = rank_b_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= ufsef_pkg::VC_RESET;
		end else if (cfg.valid && cfg.ready) begin
			vcount_q <= cfg.data;
		end
	end

	// Sequencer and forest control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_q      <= '0;
			sweep_item_q <= 1'b0;
			epoch_q      <= EPOCH_W'(1);
			count_q      <= '0;
		end else begin
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= sweep_item_q ? S_START : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						if (edges.new_graph) begin
							count_q <= '0;
						end
						// Fresh epoch makes every entry a singleton; on
						// wrap, clear stale tags before going on.
						if (edges.new_graph && epoch_q == '1) begin
							epoch_q      <= EPOCH_W'(1);
							sweep_item_q <= 1'b1;
							state_q      <= S_SWEEP;
						end else begin
							if (edges.new_graph) begin
								epoch_q <= epoch_q + 1'b1;
							end
							sweep_item_q <= 1'b0;
							state_q      <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= bad_q ? S_DONE : S_UP;
				end
				S_UP: begin
					if (rd_parent == node_q) begin
						if (node_q == start_idx) begin
							state_q <= side_q ? S_UNITE : S_START;
						end else begin
							state_q <= S_CSTART;
						end
					end
				end
				S_CSTART: begin
					state_q <= S_COMP;
				end
				S_COMP: begin
					if (rd_parent == root_sel) begin
						state_q <= side_q ? S_UNITE : S_START;
					end
				end
				S_UNITE: begin
					if (root_a_q != root_b_q && count_q != ufsef_pkg::CNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
					if (root_a_q != root_b_q && rank_a_q == rank_b_q
							&& rank_b_q != ufsef_pkg::RANK_MAX) begin
						state_q <= S_RANK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RANK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || results.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-edge working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					a_idx_q <= IDX_W'(edges.end_a - 1'b1);
					b_idx_q <= IDX_W'(edges.end_b - 1'b1);
					bad_q   <= edge_bad;
					last_q  <= edges.last_edge;
					acc_q   <= 1'b0;
					side_q  <= 1'b0;
				end
			end
			S_START, S_CSTART: begin
				node_q <= start_idx;
			end
			S_UP: begin
				if (rd_parent == node_q) begin
					// Root found: hold it and its rank; advance to endpoint b
					// when no rewrite is needed.
					if (side_q) begin
						root_b_q <= node_q;
						rank_b_q <= rd_rank;
					end else begin
						root_a_q <= node_q;
						rank_a_q <= rd_rank;
					end
					if (node_q == start_idx) begin
						side_q <= 1'b1;
					end
				end else begin
					node_q <= rd_parent;
				end
			end
			S_COMP: begin
				if (rd_parent == root_sel) begin
					side_q <= 1'b1;
				end else begin
					node_q <= rd_parent;
				end
			end
			S_UNITE: begin
				acc_q <= (root_a_q != root_b_q);
			end
			default: begin
			end
		endcase
	end

	// Output register: load when free or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || results.ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || results.ready)) begin
			out_acc_q   <= acc_q;
			out_bad_q   <= bad_q;
			out_count_q <= count_q;
			out_span_q  <= span;
		end
	end

	// The schedule never reads and writes one entry in the same cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && ram_waddr == ram_raddr))
		else $error("forest RAM read and write hit the same entry");

	// Path rewrite never targets the root itself.
	a_comp_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMP |-> node_q != root_sel)
		else $error("path compression rewrote a root");

	// Tree count only drops on a new graph.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && edges.new_graph) |=> count_q >= $past(count_q))
		else $error("tree count decreased without a new graph");

	// A bad edge is never reported as accepted.
	a_bad_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_acc_q && out_bad_q))
		else $error("bad edge reported as accepted");

endmodule

>>> verif/tb_union_find_spanning_edge_filter_core.sv
// Self-checking testbench for the union-find spanning-edge filter core.
`timescale 1ns / 1ps

import ufsef_pkg::*;

// One edge word as offered on the edges channel.
typedef struct packed {
	logic [END_W-1:0] end_a;
	logic [END_W-1:0] end_b;
	logic             new_graph;
	logic             last_edge;
} edge_word_t;

// One result word as returned on the results channel.
typedef struct packed {
	logic             accepted;
	logic             bad_vertex;
	logic [CNT_W-1:0] tree_edges;
	logic             spanning_found;
} verdict_t;

// Shadow disjoint-set forest: works out each edge's verdict and checks returned words.
class edge_verdict_board;
	logic [IDX_W-1:0]  parent_of [MAX_VERTICES];
	logic [RANK_W-1:0] rank_of [MAX_VERTICES];
	logic [CNT_W-1:0]  tree_count;
	logic [END_W-1:0]  vertex_count;
	verdict_t          owed_verdicts [$];
	int                mismatches;
	int                edges_taken;
	int                verdicts_seen;
	int                joins;
	int                bad_edges;
	int                spans;

	function new();
		clear_forest();
		vertex_count = VC_RESET;
	endfunction

	function void clear_forest();
		for (int i = 0; i < MAX_VERTICES; i++) begin
			parent_of[i] = IDX_W'(i);
			rank_of[i]   = '0;
		end
		tree_count = '0;
	endfunction

	// Climb to the root, then point every node on the way straight at it.
	function logic [IDX_W-1:0] root_of(logic [IDX_W-1:0] v);
		logic [IDX_W-1:0] root;
		logic [IDX_W-1:0] next;
		root = v;
		while (parent_of[root] != root)
			root = parent_of[root];
		while (v != root) begin
			next         = parent_of[v];
			parent_of[v] = root;
			v            = next;
		end
		return root;
	endfunction

	function int owed();
		return owed_verdicts.size();
	endfunction

	function void note_edge(edge_word_t w);
		int               vc;
		logic [IDX_W-1:0] ra;
		logic [IDX_W-1:0] rb;
		verdict_t         v;
		vc = (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
		if (w.new_graph)
			clear_forest();
		v = '0;
		v.bad_vertex = (w.end_a == 0) || (w.end_b == 0) ||
			(int'(w.end_a) > vc) || (int'(w.end_b) > vc);
		if (!v.bad_vertex) begin
			ra = root_of(IDX_W'(w.end_a - 1'b1));
			rb = root_of(IDX_W'(w.end_b - 1'b1));
			if (ra != rb) begin
				// union by rank; on a tie the second root wins and grows
				if (rank_of[ra] > rank_of[rb]) begin
					parent_of[rb] = ra;
				end else begin
					parent_of[ra] = rb;
					if (rank_of[ra] == rank_of[rb] && rank_of[rb] != RANK_MAX)
						rank_of[rb] = rank_of[rb] + 1'b1;
				end
				v.accepted = 1'b1;
				if (tree_count != CNT_MAX)
					tree_count = tree_count + 1'b1;
			end
		end
		v.tree_edges     = tree_count;
		v.spanning_found = w.last_edge && vc >= 1 && int'(tree_count) == vc - 1;
		owed_verdicts.push_back(v);
		edges_taken++;
		joins     += v.accepted;
		bad_edges += v.bad_vertex;
		spans     += v.spanning_found;
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function void check_verdict(verdict_t got);
		verdict_t want;
		verdicts_seen++;
		if (owed_verdicts.size() == 0) begin
			$error("result word with no edge outstanding: %p", got);
			mismatches++;
			return;
		end
		want = owed_verdicts.pop_front();
		compare_field("accepted", want.accepted, got.accepted);
		compare_field("bad_vertex", want.bad_vertex, got.bad_vertex);
		compare_field("tree_edges", want.tree_edges, got.tree_edges);
		compare_field("spanning_found", want.spanning_found, got.spanning_found);
	endfunction
endclass

module tb_union_find_spanning_edge_filter_core;

	// Stimulus budget and timing knobs.
	localparam int EDGE_BUDGET  = 1150;
	localparam int HOLD_CYCLES  = 400;   // long result back-pressure stretch
	localparam int QUIET_GAP    = 60;    // idle cycles before a register write
	localparam int END_SETTLE   = 100;   // cycles to watch for stray words at the end
	localparam int STALL_LIMIT  = 6000;  // covers a clearing pass plus the long hold

	logic clk = 1'b0;
	logic arst_n;

	ufsef_edge_if   edge_bus ();
	ufsef_result_if verdict_bus ();
	ufsef_cfg_if    cfg_bus ();

	union_find_spanning_edge_filter_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.edges   (edge_bus),
		.results (verdict_bus),
		.cfg     (cfg_bus)
	);

	edge_verdict_board board = new();

	// Remaining items in a stretch without idling, one per side.
	int tx_calm = 0;
	int rx_calm = 0;
	// Raised by the sender to make the result side back off for a long stretch.
	bit hold_on = 1'b0;
	int cfg_writes = 0;
	int vertex_order [MAX_VERTICES];

	always #5 clk = ~clk;

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Draw a random pause; now and then start a stretch with no pauses.
	function automatic int draw_pause(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (chance(4))
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 16);
	endfunction

	function automatic edge_word_t build_edge(int a, int b, bit ng, bit le);
		edge_word_t w;
		w.end_a     = END_W'(a);
		w.end_b     = END_W'(b);
		w.new_graph = ng;
		w.last_edge = le;
		return w;
	endfunction

	// Pick an endpoint that is out of range for a graph of vc vertices,
	// or any 11-bit value.
	function automatic logic [END_W-1:0] stray_end(int vc);
		case ($urandom_range(0, 2))
			0: return '0;
			1: return END_W'($urandom_range(vc + 1, 2047));
			default: return END_W'($urandom);
		endcase
	endfunction

	// Offer one edge word: idle first, then hold valid until it is taken.
	// Record the word with the board on the accepting edge.
	task automatic offer_edge(edge_word_t w);
		int gap;
		gap = draw_pause(tx_calm);
		if (gap > 0) begin
			edge_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		edge_bus.valid     <= 1'b1;
		edge_bus.end_a     <= w.end_a;
		edge_bus.end_b     <= w.end_b;
		edge_bus.new_graph <= w.new_graph;
		edge_bus.last_edge <= w.last_edge;
		do begin
			@(posedge clk);
		end while (!edge_bus.ready);
		board.note_edge(w);
	endtask

	// Drop valid and wait until every owed result word is back, then let the
	// block go quiet.
	task automatic drain_results();
		edge_bus.valid <= 1'b0;
		while (board.owed() != 0)
			@(posedge clk);
		repeat (QUIET_GAP) @(posedge clk);
	endtask

	// Write vertex_count only once the block is idle.
	task automatic write_vertex_count(int v);
		drain_results();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= END_W'(v);
		do begin
			@(posedge clk);
		end while (!cfg_bus.ready);
		cfg_bus.valid      <= 1'b0;
		board.vertex_count = END_W'(v);
		cfg_writes++;
	endtask

	// Build one graph over vertices 1..vc: a random tree over k of them
	// (a few tree edges dropped), plus extra edges that mostly close cycles.
	// Shuffle the lot and sprinkle in bad endpoints and stray flags.
	task automatic offer_graph(int vc, int k, int extras, bit fresh);
		edge_word_t plan [$];
		edge_word_t w;
		int         i;
		int         j;
		int         t;
		for (i = 0; i < vc; i++)
			vertex_order[i] = i + 1;
		for (i = vc - 1; i > 0; i--) begin
			j               = $urandom_range(0, i);
			t               = vertex_order[i];
			vertex_order[i] = vertex_order[j];
			vertex_order[j] = t;
		end
		for (i = 1; i < k; i++) begin
			if (chance(4))
				continue;
			// chain links now and then so the forest grows taller
			j = chance(30) ? i - 1 : $urandom_range(0, i - 1);
			w = build_edge(vertex_order[i], vertex_order[j], 1'b0, 1'b0);
			if (chance(50))
				w = build_edge(vertex_order[j], vertex_order[i], 1'b0, 1'b0);
			plan.push_back(w);
		end
		for (i = 0; i < extras || plan.size() == 0; i++) begin
			if (vc == 0)
				w = build_edge(stray_end(vc), stray_end(vc), 1'b0, 1'b0);
			else
				w = build_edge($urandom_range(1, vc), $urandom_range(1, vc), 1'b0, 1'b0);
			plan.push_back(w);
		end
		for (i = plan.size() - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			w       = plan[i];
			plan[i] = plan[j];
			plan[j] = w;
		end
		for (i = 0; i < plan.size(); i++) begin
			w = plan[i];
			if (chance(6))
				w.end_a = stray_end(vc);
			if (chance(6))
				w.end_b = stray_end(vc);
			w.new_graph = (i == 0) ? fresh : chance(2);
			w.last_edge = (i == plan.size() - 1) || chance(2);
			offer_edge(w);
		end
	endtask

	// Result side: pause at random, then take one word and check it.
	initial begin : verdict_sink
		int       gap;
		verdict_t seen;
		forever begin
			if (hold_on) begin
				// long back-pressure: keep ready low until the hold timer lets go
				verdict_bus.ready <= 1'b0;
				wait (!hold_on);
			end else begin
				gap = draw_pause(rx_calm);
				if (gap > 0) begin
					verdict_bus.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			verdict_bus.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!verdict_bus.valid);
			seen.accepted       = verdict_bus.accepted;
			seen.bad_vertex     = verdict_bus.bad_vertex;
			seen.tree_edges     = verdict_bus.tree_edges;
			seen.spanning_found = verdict_bus.spanning_found;
			board.check_verdict(seen);
		end
	end

	// Count out the long hold in cycles, then release the result side.
	initial begin : long_hold
		wait (hold_on);
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
	end

	// Abort when no word moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((edge_bus.valid && edge_bus.ready) ||
					(verdict_bus.valid && verdict_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$error("no word moved for %0d cycles", STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int phase_no;
		int pick;
		int vc;
		int eff;
		int k;
		int graphs;

		// hold every input at a known value through reset
		arst_n             <= 1'b0;
		edge_bus.valid     <= 1'b0;
		edge_bus.end_a     <= '0;
		edge_bus.end_b     <= '0;
		edge_bus.new_graph <= 1'b0;
		edge_bus.last_edge <= 1'b0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.data       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, starting from the reset vertex count of 1024:
		// join the extreme vertices, then repeat the same pair reversed.
		offer_edge(build_edge(1, 1024, 1'b1, 1'b0));
		offer_edge(build_edge(1024, 1, 1'b0, 1'b0));
		// zero endpoints, endpoints past the count, all-ones endpoints
		offer_edge(build_edge(0, 5, 1'b0, 1'b0));
		offer_edge(build_edge(5, 0, 1'b0, 1'b0));
		offer_edge(build_edge(1025, 3, 1'b0, 1'b0));
		offer_edge(build_edge(2047, 2047, 1'b0, 1'b0));
		// a self loop never joins anything
		offer_edge(build_edge(7, 7, 1'b0, 1'b0));
		offer_edge(build_edge(512, 1023, 1'b0, 1'b1));
		// new_graph riding on a bad edge still clears the forest
		offer_edge(build_edge(0, 0, 1'b1, 1'b0));
		offer_edge(build_edge(2, 1024, 1'b0, 1'b1));

		// two vertices: one edge spans, a bad last edge still reports it
		write_vertex_count(2);
		offer_edge(build_edge(1, 2, 1'b1, 1'b1));
		offer_edge(build_edge(3, 1, 1'b0, 1'b1));

		// zero vertices: everything is bad and nothing spans
		write_vertex_count(0);
		offer_edge(build_edge(1, 1, 1'b1, 1'b1));
		offer_edge(build_edge(1, 0, 1'b0, 1'b0));

		// a count past capacity acts as full capacity
		write_vertex_count(2047);
		offer_edge(build_edge(1024, 1, 1'b1, 1'b0));
		offer_edge(build_edge(1025, 1, 1'b0, 1'b0));
		offer_edge(build_edge(1024, 512, 1'b0, 1'b1));

		// a single vertex spans with no edges at all
		write_vertex_count(1);
		offer_edge(build_edge(1, 1, 1'b1, 1'b1));
		offer_edge(build_edge(1, 2, 1'b0, 1'b1));

		// grow the count mid-graph: forest and tally carry over
		write_vertex_count(4);
		offer_edge(build_edge(3, 4, 1'b0, 1'b0));
		offer_edge(build_edge(1, 3, 1'b0, 1'b0));
		offer_edge(build_edge(2, 4, 1'b0, 1'b1));

		// Random part: phases of graphs, each phase after a drain and
		// mostly with a fresh vertex count.
		phase_no = 0;
		vc       = 4;
		while (board.edges_taken < EDGE_BUDGET) begin
			phase_no++;
			case (phase_no)
				3: begin
					// one mid-size spanning graph with deep-ish trees
					vc = 200;
					write_vertex_count(vc);
					offer_graph(vc, vc, 40, 1'b1);
				end
				6: begin
					// partial tree spread over the full vertex range
					vc = 1024;
					write_vertex_count(vc);
					offer_graph(vc, 100, 40, 1'b1);
				end
				9: begin
					// Burst of one-edge graphs: many forest clears in a row, and
					// the result side backs off so the block fills and stalls.
					vc = $urandom_range(2, 8);
					write_vertex_count(vc);
					hold_on = 1'b1;
					repeat (300)
						offer_edge(build_edge($urandom_range(0, vc + 1),
							$urandom_range(0, vc + 1), 1'b1, chance(50)));
				end
				default: begin
					if (chance(80)) begin
						pick = $urandom_range(0, 99);
						if (pick < 65)
							vc = $urandom_range(1, 24);
						else if (pick < 80)
							vc = $urandom_range(25, 64);
						else if (pick < 86)
							vc = 0;
						else if (pick < 92)
							vc = $urandom_range(1025, 2047);
						else
							vc = $urandom_range(65, 1024);
						write_vertex_count(vc);
					end else begin
						drain_results();
					end
					eff    = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
					graphs = $urandom_range(1, 3);
					repeat (graphs) begin
						if (eff <= 64)
							k = chance(75) ? eff : $urandom_range(0, eff);
						else
							k = $urandom_range(2, 40);
						offer_graph(eff, k, $urandom_range(0, 6) + ((eff <= 64) ? eff / 3 : 8),
							chance(85));
					end
				end
			endcase
		end

		drain_results();
		repeat (END_SETTLE) @(posedge clk);

		$display("Covered %0d edges under %0d vertex-count writes: %0d joined two sets, %0d bad.",
			board.edges_taken, cfg_writes, board.joins, board.bad_edges);
		$display("Checked %0d result words, %0d of them reporting a spanning tree.",
			board.verdicts_seen, board.spans);
		if (board.mismatches == 0 && board.owed() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
